// File: rtl/strongly_connected_components_unit_macros.svh
// Assertion macros shared by the block.
`ifndef STRONGLY_CONNECTED_COMPONENTS_UNIT_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EDGE_W + 1;
    localparam int FIELD_W = 7;
    localparam int NCNT_W = NODE_W + 1;

    // Node store: four regions of MAX_NODES words, each word {node, cursor}.
    localparam int WALK_W = NODE_W + ECNT_W;
    localparam int NRAM_DEPTH = 4 * MAX_NODES;
    localparam int NRAM_AW = $clog2(NRAM_DEPTH);

    localparam logic [1:0] REGION_WALK = 2'd0;
    localparam logic [1:0] REGION_FIN = 2'd1;
    localparam logic [1:0] REGION_LABEL = 2'd2;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [FIELD_W-1:0]  edge_from;
        logic [FIELD_W-1:0]  edge_to;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0]  node_id;
        logic [FIELD_W-1:0]  component_label;
        logic                last;
    } t_out_item;
endpackage

// File: rtl/scc_if.sv
`timescale 1ns / 1ps
interface scc_in_if;
    import scc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface scc_out_if;
    import scc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/scc_ram.sv
`timescale 1ns / 1ps
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/strongly_connected_components_unit.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                               Request taken when
// i_req      in   req_type, edge_from, edge_to          valid && ready
// o_res      out  node_id, component_label, last        valid && ready
// cfg        in   num_nodes (7 bits)                    i_cfg_we
// An add-edge request leaves the unit idle, so add requests may follow back to back.
// A run request walks the graph; every walk step scans the edge store through its
// one read port. Labels then leave in node order, each read from the node store before
// it is sent; a held output stalls them. The input is ready only while idle. Reset is
// synchronous and active low; it clears the edge count and sets num_nodes to 64.
`include "strongly_connected_components_unit_macros.svh"
module strongly_connected_components_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [6:0]            i_cfg_wdata,
    scc_in_if.sink                i_req,
    scc_out_if.source             o_res
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_P1_ROOT, S_P1_SCAN, S_P1_POP, S_P1_LOAD,
        S_P2_ROOT, S_P2_PICK, S_P2_SCAN, S_P2_STEP, S_P2_LOAD,
        S_EMIT_RD, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic [FIELD_W-1:0]   r_num_nodes;
    logic [ECNT_W-1:0]    r_edge_count, n_edge_count;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [NCNT_W-1:0]    r_fin_top, n_fin_top;
    logic [NCNT_W-1:0]    r_wtop, n_wtop;
    // The top walk entry's node is held here; entries below it live in the node store.
    logic [NODE_W-1:0]    r_top_node, n_top_node;
    logic [NCNT_W-1:0]    r_root, n_root;
    logic [ECNT_W-1:0]    r_e, n_e;         // edge being issued to the store
    logic                 r_rd_v, n_rd_v;   // read data valid this cycle
    logic [ECNT_W-1:0]    r_e_rd, n_e_rd;   // edge index of the read data
    logic [NCNT_W-1:0]    r_best, n_best;
    logic [FIELD_W-1:0]   r_label, n_label;
    logic [NCNT_W-1:0]    r_emit, n_emit;
    logic                 r_out_v, n_out_v;
    t_out_item            r_out, n_out;

    // Effective node count.
    logic [NCNT_W-1:0] w_nodes;
    always_comb begin
        if (r_num_nodes == '0) w_nodes = NCNT_W'(1);
        else if (r_num_nodes > FIELD_W'(MAX_NODES)) w_nodes = NCNT_W'(MAX_NODES);
        else w_nodes = r_num_nodes[NCNT_W-1:0];
    end

    // Edge store: source and destination in one word.
    logic               w_we;
    logic [EDGE_W-1:0]  w_waddr, w_raddr;
    logic [2*NODE_W-1:0] w_wdata, w_rdata;
    logic [NODE_W-1:0]  w_src, w_dst;
    scc_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    assign w_src = w_rdata[2*NODE_W-1:NODE_W];
    assign w_dst = w_rdata[NODE_W-1:0];

    // Node store: buried walk entries, finish order and labels in separate regions.
    // A walk entry is written on a push and read back only after a full scan, so no
    // access to one entry can overlap another.
    logic               m_we;
    logic [NRAM_AW-1:0] m_waddr, m_raddr;
    logic [WALK_W-1:0]  m_wdata, m_rdata;
    logic [NODE_W-1:0]  m_node;
    logic [ECNT_W-1:0]  m_cursor;
    scc_ram #(.WIDTH(WALK_W), .DEPTH(NRAM_DEPTH)) u_nodes (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    assign m_node = m_rdata[WALK_W-1:ECNT_W];
    assign m_cursor = m_rdata[ECNT_W-1:0];

    logic w_in_acc, w_ok_edge, w_scan_end;
    assign w_in_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_ok_edge = i_req.payload.edge_from >= FIELD_W'(1)
        && i_req.payload.edge_from <= FIELD_W'(w_nodes)
        && i_req.payload.edge_to >= FIELD_W'(1)
        && i_req.payload.edge_to <= FIELD_W'(w_nodes)
        && r_edge_count < ECNT_W'(MAX_EDGES);
    assign w_we = (r_state == S_IDLE) && w_in_acc
        && i_req.payload.req_type == REQ_ADD && w_ok_edge;
    assign w_waddr = r_edge_count[EDGE_W-1:0];
    assign w_wdata = {NODE_W'(i_req.payload.edge_from - FIELD_W'(1)),
                      NODE_W'(i_req.payload.edge_to - FIELD_W'(1))};
    assign w_raddr = r_e[EDGE_W-1:0];
    assign w_scan_end = (r_e_rd >= r_edge_count);
    assign o_res.valid = r_out_v;
    assign o_res.payload = r_out;

    // Next values of the sequencer and node store accesses.
    always_comb begin
        n_state = r_state;
        n_edge_count = r_edge_count;
        n_visited = r_visited;
        n_fin_top = r_fin_top;
        n_wtop = r_wtop;
        n_top_node = r_top_node;
        n_root = r_root;
        n_e = r_e;
        n_e_rd = r_e_rd;
        n_rd_v = 1'b0;
        n_best = r_best;
        n_label = r_label;
        n_emit = r_emit;
        n_out_v = r_out_v;
        n_out = r_out;
        m_we = 1'b0;
        m_waddr = {REGION_WALK, NODE_W'(0)};
        m_wdata = '0;
        m_raddr = {REGION_LABEL, r_emit[NODE_W-1:0]};
        if (r_out_v && o_res.ready) n_out_v = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_we) n_edge_count = r_edge_count + ECNT_W'(1);
                if (w_in_acc && i_req.payload.req_type == REQ_RUN) begin
                    n_visited = '0;
                    n_fin_top = '0;
                    n_wtop = '0;
                    n_root = '0;
                    n_state = S_P1_ROOT;
                end
            end
            S_P1_ROOT: begin
                if (r_root >= w_nodes) begin
                    n_visited = '0;
                    n_label = '0;
                    n_state = S_P2_ROOT;
                end else begin
                    if (!r_visited[r_root[NODE_W-1:0]]) begin
                        n_visited[r_root[NODE_W-1:0]] = 1'b1;
                        n_top_node = r_root[NODE_W-1:0];
                        n_wtop = NCNT_W'(1);
                        n_e = '0;
                        n_state = S_P1_SCAN;
                    end
                    n_root = r_root + NCNT_W'(1);
                end
            end
            S_P1_SCAN: begin
                // Issue reads from the top entry's cursor; examine one read per cycle.
                n_e = r_e + ECNT_W'(1);
                n_e_rd = r_e;
                n_rd_v = 1'b1;
                if (r_rd_v) begin
                    if (w_scan_end) begin
                        n_rd_v = 1'b0;
                        n_state = S_P1_POP;
                    end else if (w_src == r_top_node && NCNT_W'(w_dst) < w_nodes
                                 && !r_visited[w_dst]) begin
                        // Bury the top entry with its resume cursor and push the neighbor.
                        m_we = 1'b1;
                        m_waddr = {REGION_WALK, NODE_W'(r_wtop - NCNT_W'(1))};
                        m_wdata = {r_top_node, r_e_rd + ECNT_W'(1)};
                        n_visited[w_dst] = 1'b1;
                        n_top_node = w_dst;
                        n_wtop = r_wtop + NCNT_W'(1);
                        n_e = '0;
                        n_rd_v = 1'b0;
                    end
                end
            end
            S_P1_POP: begin
                m_we = 1'b1;
                m_waddr = {REGION_FIN, r_fin_top[NODE_W-1:0]};
                m_wdata = {r_top_node, ECNT_W'(0)};
                n_fin_top = r_fin_top + NCNT_W'(1);
                n_wtop = r_wtop - NCNT_W'(1);
                if (r_wtop == NCNT_W'(1)) begin
                    n_state = S_P1_ROOT;
                end else begin
                    m_raddr = {REGION_WALK, NODE_W'(r_wtop - NCNT_W'(2))};
                    n_state = S_P1_LOAD;
                end
            end
            S_P1_LOAD: begin
                n_top_node = m_node;
                n_e = m_cursor;
                n_state = S_P1_SCAN;
            end
            S_P2_ROOT: begin
                if (r_fin_top == '0) begin
                    n_emit = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    m_raddr = {REGION_FIN, NODE_W'(r_fin_top - NCNT_W'(1))};
                    n_fin_top = r_fin_top - NCNT_W'(1);
                    n_state = S_P2_PICK;
                end
            end
            S_P2_PICK: begin
                if (NCNT_W'(m_node) < w_nodes && !r_visited[m_node]) begin
                    n_label = r_label + FIELD_W'(1);
                    n_visited[m_node] = 1'b1;
                    n_top_node = m_node;
                    n_wtop = NCNT_W'(1);
                    n_e = '0;
                    n_best = w_nodes;
                    n_state = S_P2_SCAN;
                end else begin
                    n_state = S_P2_ROOT;
                end
            end
            S_P2_SCAN: begin
                n_e = r_e + ECNT_W'(1);
                n_e_rd = r_e;
                n_rd_v = 1'b1;
                if (r_rd_v) begin
                    if (w_scan_end) begin
                        n_rd_v = 1'b0;
                        n_state = S_P2_STEP;
                    end else if (w_dst == r_top_node && NCNT_W'(w_src) < r_best
                                 && !r_visited[w_src]) begin
                        n_best = NCNT_W'(w_src);
                    end
                end
            end
            S_P2_STEP: begin
                n_e = '0;
                if (r_best < w_nodes) begin
                    m_we = 1'b1;
                    m_waddr = {REGION_WALK, NODE_W'(r_wtop - NCNT_W'(1))};
                    m_wdata = {r_top_node, ECNT_W'(0)};
                    n_visited[r_best[NODE_W-1:0]] = 1'b1;
                    n_top_node = r_best[NODE_W-1:0];
                    n_wtop = r_wtop + NCNT_W'(1);
                    n_best = w_nodes;
                    n_state = S_P2_SCAN;
                end else begin
                    // Every node of the tree is popped under the current label.
                    m_we = 1'b1;
                    m_waddr = {REGION_LABEL, r_top_node};
                    m_wdata = WALK_W'(r_label);
                    n_wtop = r_wtop - NCNT_W'(1);
                    if (r_wtop == NCNT_W'(1)) begin
                        n_state = S_P2_ROOT;
                    end else begin
                        m_raddr = {REGION_WALK, NODE_W'(r_wtop - NCNT_W'(2))};
                        n_state = S_P2_LOAD;
                    end
                end
            end
            S_P2_LOAD: begin
                n_top_node = m_node;
                n_state = S_P2_SCAN;
            end
            S_EMIT_RD: begin
                // Label read for r_emit is issued; data is ready next cycle.
                if (!r_out_v || o_res.ready) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_v || o_res.ready) begin
                    n_out_v = 1'b1;
                    n_out.node_id = FIELD_W'(r_emit + NCNT_W'(1));
                    n_out.component_label = m_rdata[FIELD_W-1:0];
                    n_out.last = (r_emit + NCNT_W'(1) == w_nodes);
                    if (r_emit + NCNT_W'(1) == w_nodes) begin
                        n_edge_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_emit = r_emit + NCNT_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_num_nodes <= FIELD_W'(MAX_NODES);
            r_edge_count <= '0;
            r_out_v <= 1'b0;
            r_fin_top <= '0;
            r_wtop <= '0;
            r_rd_v <= 1'b0;
            r_e <= '0;
            r_emit <= '0;
        end else begin
            if (i_cfg_we) r_num_nodes <= i_cfg_wdata;
            r_state <= n_state;
            r_edge_count <= n_edge_count;
            r_out_v <= n_out_v;
            r_fin_top <= n_fin_top;
            r_wtop <= n_wtop;
            r_rd_v <= n_rd_v;
            r_e <= n_e;
            r_emit <= n_emit;
        end
        r_visited <= n_visited;
        r_top_node <= n_top_node;
        r_root <= n_root;
        r_e_rd <= n_e_rd;
        r_best <= n_best;
        r_label <= n_label;
        r_out <= n_out;
    end

    `SCC_ASSERT_IMP(a_edge_count_max, i_clk, i_rst_n, 1'b1, r_edge_count <= ECNT_W'(MAX_EDGES))
    `SCC_ASSERT_IMP(a_wtop_max, i_clk, i_rst_n, 1'b1, r_wtop <= NCNT_W'(MAX_NODES))
    `SCC_ASSERT_IMP(a_fin_max, i_clk, i_rst_n, 1'b1, r_fin_top <= w_nodes)
    `SCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_v && !o_res.ready, r_out_v && $stable(r_out))
endmodule
